### rtl/core/assert_macros.svh
// Concurrent assertion macros shared by the filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
		else $error("%m: check failed");

// Check that a condition holds in the cycle after a trigger.
`define ASSERT_NEXT(lbl, clk, rst_n, trig, cond) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |=> (cond)) \
		else $error("%m: check failed");

`endif

### rtl/core/skdf_pkg.sv
// Types and constants for the scalar Kalman distance filter.
package skdf_pkg;

	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_UNC     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PROC_NOISE   = 2'd2;

	localparam logic [31:0] MEAS_NOISE_RST = 32'd131072;
	localparam logic [31:0] INIT_UNC_RST   = 32'd131072;
	localparam logic [31:0] PROC_NOISE_RST = 32'd655;

	localparam logic [16:0] ONE_Q16 = 17'h10000;
	localparam logic [8:0]  MAX_CM  = 9'd400;
	localparam logic signed [9:0] NO_ECHO_CM = -10'sd1;

	localparam int unsigned DIV_STEPS = 17;
	localparam int unsigned DIV_CNT_W = 5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL_GAIN,
		ST_MUL_DECAY,
		ST_MUL_NOISE,
		ST_SUM,
		ST_DONE
	} ctrl_state_t;

	typedef enum logic [1:0] {
		MUL_GAIN,
		MUL_DECAY,
		MUL_NOISE
	} mul_sel_t;

	typedef struct packed {
		logic     capture;
		logic     div_step;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     est_update;
		logic     acc_load;
		logic     unc_update;
		logic     out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic no_echo_in;
		logic div_last;
	} dp_sts_t;

endpackage

### rtl/core/skdf_ctrl.sv
// Sequencing state machine for the filter datapath and output handshake.
`include "assert_macros.svh"

module skdf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  skdf_pkg::dp_sts_t sts,
	output skdf_pkg::dp_cmd_t cmd
);
	import skdf_pkg::*;

	ctrl_state_t state_q, state_d;
	logic        out_valid_q;
	logic        in_xfer;
	logic        out_free;

	assign in_xfer  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = sts.no_echo_in ? ST_DONE : ST_DIV;
				end
			end
			ST_DIV: begin
				if (sts.div_last) begin
					state_d = ST_MUL_GAIN;
				end
			end
			ST_MUL_GAIN:  state_d = ST_MUL_DECAY;
			ST_MUL_DECAY: state_d = ST_MUL_NOISE;
			ST_MUL_NOISE: state_d = ST_SUM;
			ST_SUM:       state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.mul_sel  = MUL_GAIN;
		in_stall     = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.capture = in_valid;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
			end
			ST_MUL_GAIN: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_GAIN;
			end
			ST_MUL_DECAY: begin
				cmd.mul_en     = 1'b1;
				cmd.mul_sel    = MUL_DECAY;
				cmd.est_update = 1'b1;
			end
			ST_MUL_NOISE: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = MUL_NOISE;
				cmd.acc_load = 1'b1;
			end
			ST_SUM: begin
				cmd.unc_update = 1'b1;
			end
			ST_DONE: begin
				cmd.out_load = out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`ASSERT_NEXT(a_no_echo_short, clk, arst_n, in_xfer && sts.no_echo_in, state_q == ST_DONE)
	`ASSERT_HOLDS(a_load_free, clk, arst_n, !cmd.out_load || !(out_valid_q && out_stall))
	`ASSERT_NEXT(a_div_hold, clk, arst_n, state_q == ST_DIV && !sts.div_last, state_q == ST_DIV)

endmodule

### rtl/core/skdf_dp.sv
// Filter datapath: registers, serial gain divider, shared multiplier, result register.
`include "assert_macros.svh"

module skdf_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic signed [9:0]                   reading_cm,
	input  logic                                cfg_we,
	input  logic [skdf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [31:0]                         cfg_data,
	input  skdf_pkg::dp_cmd_t                   cmd,
	output skdf_pkg::dp_sts_t                   sts,
	output logic signed [9:0]                   distance_cm,
	output logic [24:0]                         estimate_fixed,
	output logic [16:0]                         gain,
	output logic                                no_echo
);
	import skdf_pkg::*;

	logic [31:0] meas_noise_q, proc_noise_q;
	logic [31:0] unc_q;
	logic [24:0] est_q;
	logic [16:0] gain_q;

	logic [24:0] meas_q, dist_q, step_q;
	logic        up_q, no_echo_q, dz_q;
	logic [32:0] denom_q, rem_q;
	logic [16:0] quot_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [56:0] mul_q, acc_q;

	logic signed [9:0] distance_q;
	logic [24:0]       estimate_q;
	logic [16:0]       gain_out_q;
	logic              no_echo_out_q;

	logic [8:0]  cm_w;
	logic [32:0] denom_w;
	logic [33:0] div_sh;
	logic        div_ge;
	logic        num_bit;
	logic [16:0] g_w;
	logic [31:0] mul_a;
	logic [24:0] mul_b;
	logic [24:0] step_w;
	logic [57:0] sum_w;
	logic [41:0] unc_w;

	assign sts.no_echo_in = (reading_cm == NO_ECHO_CM);
	assign sts.div_last   = (div_cnt_q == '0);

	always_comb begin
		if (reading_cm < 0) begin
			cm_w = '0;
		end else if (reading_cm > signed'({1'b0, MAX_CM})) begin
			cm_w = MAX_CM;
		end else begin
			cm_w = reading_cm[8:0];
		end
	end

	assign denom_w = {1'b0, unc_q} + {1'b0, meas_noise_q};
	assign num_bit = (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) ? unc_q[0] : 1'b0;
	assign div_sh  = {rem_q, num_bit};
	assign div_ge  = div_sh >= {1'b0, denom_q};
	assign g_w     = dz_q ? '0 : quot_q;

	always_comb begin
		case (cmd.mul_sel)
			MUL_GAIN: begin
				mul_a = {7'd0, dist_q};
				mul_b = {8'd0, g_w};
			end
			MUL_DECAY: begin
				mul_a = unc_q;
				mul_b = {8'd0, 17'(ONE_Q16 - g_w)};
			end
			MUL_NOISE: begin
				mul_a = proc_noise_q;
				mul_b = step_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign step_w = mul_q[40:16];
	assign sum_w  = {1'b0, acc_q} + {1'b0, mul_q};
	assign unc_w  = sum_w[57:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meas_noise_q <= MEAS_NOISE_RST;
			proc_noise_q <= PROC_NOISE_RST;
			unc_q        <= INIT_UNC_RST;
			est_q        <= '0;
			gain_q       <= '0;
			div_cnt_q    <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MEAS_NOISE: meas_noise_q <= cfg_data;
					REG_INIT_UNC:   unc_q        <= cfg_data;
					REG_PROC_NOISE: proc_noise_q <= cfg_data;
					default:        ;
				endcase
			end
			if (cmd.capture) begin
				div_cnt_q <= DIV_CNT_W'(DIV_STEPS - 1);
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q - 1'b1;
			end
			if (cmd.est_update) begin
				est_q  <= up_q ? est_q + step_w : est_q - step_w;
				gain_q <= g_w;
			end
			if (cmd.unc_update) begin
				unc_q <= (|unc_w[41:32]) ? '1 : unc_w[31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			meas_q    <= {cm_w, 16'd0};
			no_echo_q <= sts.no_echo_in;
			denom_q   <= denom_w;
			dz_q      <= (denom_w == '0);
			rem_q     <= {2'd0, unc_q[31:1]};
		end
		if (cmd.div_step) begin
			rem_q  <= div_ge ? 33'(div_sh - {1'b0, denom_q}) : div_sh[32:0];
			quot_q <= {quot_q[15:0], div_ge};
			up_q   <= meas_q >= est_q;
			dist_q <= (meas_q >= est_q) ? meas_q - est_q : est_q - meas_q;
		end
		if (cmd.mul_en) begin
			mul_q <= mul_a * mul_b;
		end
		if (cmd.est_update) begin
			step_q <= step_w;
		end
		if (cmd.acc_load) begin
			acc_q <= mul_q;
		end
		if (cmd.out_load) begin
			distance_q    <= no_echo_q ? NO_ECHO_CM : signed'({1'b0, est_q[24:16]});
			estimate_q    <= est_q;
			gain_out_q    <= gain_q;
			no_echo_out_q <= no_echo_q;
		end
	end

	assign distance_cm    = distance_q;
	assign estimate_fixed = estimate_q;
	assign gain           = gain_out_q;
	assign no_echo        = no_echo_out_q;

	`ASSERT_HOLDS(a_gain_range, clk, arst_n, !gain_q[16] || (gain_q[15:0] == '0))

endmodule

### rtl/core/scalar_kalman_distance_filter_top.sv
// Scalar Kalman distance filter: top level joining controller and datapath.
// Sequence: each accepted reading runs the 17-step serial gain divider, three passes
// through the shared 32x25 multiplier, the final sum, the result load and idle.
// A no-echo reading skips straight to the result load. in_stall stays high until idle, so
// one reading is in flight at a time. A waiting result does not block the next transfer.
// Reset: asynchronous, active low; configuration registers, estimate, gain and uncertainty take defaults.
module scalar_kalman_distance_filter_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic signed [9:0]               reading_cm,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [9:0]               distance_cm,
	output logic [24:0]                     estimate_fixed,
	output logic [16:0]                     gain,
	output logic                            no_echo,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [skdf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                     cfg_data
);
	import skdf_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg_ready = 1'b1;

	skdf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	skdf_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.reading_cm     (reading_cm),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.cmd            (cmd),
		.sts            (sts),
		.distance_cm    (distance_cm),
		.estimate_fixed (estimate_fixed),
		.gain           (gain),
		.no_echo        (no_echo)
	);

endmodule

### tb/scalar_kalman_distance_filter_top_tb.sv
// Self-checking testbench for the scalar Kalman distance filter: directed table then random phases.
`timescale 1ns / 1ps

module scalar_kalman_distance_filter_top_tb;
	import skdf_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 4000;
	localparam int END_CYCLES = 30;
	localparam int PHASES = 9;
	localparam int PHASE_ITEMS = 200;

	typedef struct packed {
		logic signed [9:0] distance;
		logic [24:0]       estimate;
		logic [16:0]       gain;
		logic              no_echo;
	} filter_result_t;

	typedef enum logic {
		ROW_ITEM,
		ROW_CFG
	} row_kind_t;

	typedef struct packed {
		row_kind_t              kind;
		logic [CFG_IDX_W-1:0]   idx;
		logic [31:0]            data;
		logic signed [9:0]      reading;
		logic                   typed;
		filter_result_t         want;
	} stim_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic signed [9:0]      reading_cm = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic signed [9:0]      distance_cm;
	logic [24:0]            estimate_fixed;
	logic [16:0]            gain;
	logic                   no_echo;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [31:0]            cfg_data = '0;

	logic [31:0]            meas_noise_q = MEAS_NOISE_RST;
	logic [31:0]            proc_noise_q = PROC_NOISE_RST;
	logic [31:0]            unc_q = INIT_UNC_RST;
	logic [24:0]            est_q = '0;
	logic [16:0]            gain_q = '0;

	filter_result_t         pending_estimates[$];
	stim_row_t              directed_rows[$];
	int                     mismatches = 0;
	int                     quiet_cycles = 0;
	int                     send_idle_pct = 0;
	int                     recv_stall_pct = 0;
	int                     track_cm = 200;

	scalar_kalman_distance_filter_top u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.reading_cm     (reading_cm),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.distance_cm    (distance_cm),
		.estimate_fixed (estimate_fixed),
		.gain           (gain),
		.no_echo        (no_echo),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic filter_result_t kalman_update(input logic signed [9:0] r);
		filter_result_t res;
		logic [63:0] meas, est, denom, g, gap, stp, unc;
		int cm;
		cm = r;
		if (r == NO_ECHO_CM) begin
			res.distance = NO_ECHO_CM;
			res.estimate = est_q;
			res.gain = gain_q;
			res.no_echo = 1'b1;
			return res;
		end
		if (cm < 0)
			cm = 0;
		if (cm > int'(MAX_CM))
			cm = int'(MAX_CM);
		meas = 64'(cm) << 16;
		est = 64'(est_q);
		denom = 64'(unc_q) + 64'(meas_noise_q);
		g = '0;
		if (denom != 0)
			g = (64'(unc_q) << 16) / denom;
		if (g > 64'(ONE_Q16))
			g = 64'(ONE_Q16);
		gap = (meas >= est) ? meas - est : est - meas;
		stp = (g * gap) >> 16;
		est = (meas >= est) ? est + stp : est - stp;
		unc = ((64'(ONE_Q16) - g) * 64'(unc_q) + 64'(proc_noise_q) * stp) >> 16;
		est_q = est[24:0];
		unc_q = (unc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : unc[31:0];
		gain_q = g[16:0];
		res.distance = $signed({1'b0, est_q[24:16]});
		res.estimate = est_q;
		res.gain = gain_q;
		res.no_echo = 1'b0;
		return res;
	endfunction

	function automatic stim_row_t item_row(input logic signed [9:0] r);
		stim_row_t row;
		row = '0;
		row.kind = ROW_ITEM;
		row.reading = r;
		return row;
	endfunction

	function automatic stim_row_t check_row(input logic signed [9:0] r,
			input logic signed [9:0] d, input logic [24:0] e, input logic [16:0] g,
			input logic ne);
		stim_row_t row;
		row = item_row(r);
		row.typed = 1'b1;
		row.want = '{distance: d, estimate: e, gain: g, no_echo: ne};
		return row;
	endfunction

	function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [31:0] data);
		stim_row_t row;
		row = '0;
		row.kind = ROW_CFG;
		row.idx = idx;
		row.data = data;
		return row;
	endfunction

	function automatic logic [31:0] pick_reg_value(input logic [CFG_IDX_W-1:0] idx);
		case ($urandom_range(5))
			0: return 32'd0;
			1: return 32'd1;
			2: return 32'hFFFF_FFFF;
			3: return $urandom;
			4: return $urandom_range(32'h0040_0000);
			default: begin
				if (idx == REG_PROC_NOISE)
					return $urandom_range(32'h0001_0000);
				return $urandom_range(32'h0004_0000);
			end
		endcase
	endfunction

	function automatic logic signed [9:0] pick_reading();
		int sel;
		sel = $urandom_range(99);
		if (sel < 8)
			return NO_ECHO_CM;
		if (sel < 16)
			return 10'($urandom);
		if (sel < 22)
			return ($urandom_range(1) != 0) ? 10'sd0 : $signed({1'b0, MAX_CM});
		if (sel < 70) begin
			if ($urandom_range(19) == 0)
				track_cm = $urandom_range(int'(MAX_CM));
			track_cm = track_cm + $urandom_range(6) - 3;
			if (track_cm < 0)
				track_cm = 0;
			if (track_cm > int'(MAX_CM))
				track_cm = int'(MAX_CM);
			return 10'(track_cm);
		end
		return 10'($urandom_range(int'(MAX_CM)));
	endfunction

	task automatic report_mismatch(input string what, input longint want_v, input longint got_v);
		mismatches++;
		$display("mismatch %s: expected %0d got %0d at %0t", what, want_v, got_v, $realtime);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_estimates.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (cfg_ready !== 1'b1);
		case (idx)
			REG_MEAS_NOISE: meas_noise_q = data;
			REG_INIT_UNC:   unc_q = data;
			REG_PROC_NOISE: proc_noise_q = data;
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_reading(input logic signed [9:0] r, input logic typed,
			input filter_result_t want);
		filter_result_t res;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		reading_cm <= r;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		res = kalman_update(r);
		pending_estimates.push_back(typed ? want : res);
	endtask

	always @(posedge clk) begin
		out_stall <= arst_n && ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		filter_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_estimates.size() == 0) begin
				report_mismatch("result with none pending, distance", 0, distance_cm);
			end else begin
				want = pending_estimates.pop_front();
				if (distance_cm !== want.distance)
					report_mismatch("distance_cm", want.distance, distance_cm);
				if (estimate_fixed !== want.estimate)
					report_mismatch("estimate_fixed", want.estimate, estimate_fixed);
				if (gain !== want.gain)
					report_mismatch("gain", want.gain, gain);
				if (no_echo !== want.no_echo)
					report_mismatch("no_echo", want.no_echo, no_echo);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		logic [CFG_IDX_W-1:0] reg_order [3];
		stim_row_t row;
		int ph, n, k, start;
		reg_order = '{REG_MEAS_NOISE, REG_INIT_UNC, REG_PROC_NOISE};

		directed_rows.push_back(check_row(NO_ECHO_CM, NO_ECHO_CM, 25'd0, 17'd0, 1'b1));
		directed_rows.push_back(check_row(10'sd0, 10'sd0, 25'd0, 17'd32768, 1'b0));
		// zero denominator: gain stays zero, estimate holds
		directed_rows.push_back(cfg_row(REG_MEAS_NOISE, 32'd0));
		directed_rows.push_back(cfg_row(REG_INIT_UNC, 32'd0));
		directed_rows.push_back(check_row(10'sd400, 10'sd0, 25'd0, 17'd0, 1'b0));
		directed_rows.push_back(check_row(NO_ECHO_CM, NO_ECHO_CM, 25'd0, 17'd0, 1'b1));
		directed_rows.push_back(cfg_row(REG_UNUSED, 32'hDEAD_BEEF));
		directed_rows.push_back(check_row(10'sd400, 10'sd0, 25'd0, 17'd0, 1'b0));
		directed_rows.push_back(cfg_row(REG_MEAS_NOISE, 32'd1));
		directed_rows.push_back(cfg_row(REG_INIT_UNC, 32'hFFFF_FFFF));
		directed_rows.push_back(cfg_row(REG_PROC_NOISE, 32'hFFFF_FFFF));
		directed_rows.push_back(item_row(10'sd400));
		directed_rows.push_back(item_row(10'sd511));
		directed_rows.push_back(item_row(-10'sd512));
		directed_rows.push_back(item_row(-10'sd2));
		directed_rows.push_back(item_row(10'sd401));
		directed_rows.push_back(item_row(NO_ECHO_CM));
		directed_rows.push_back(cfg_row(REG_MEAS_NOISE, 32'hFFFF_FFFF));
		directed_rows.push_back(cfg_row(REG_PROC_NOISE, 32'd0));
		directed_rows.push_back(item_row(10'sd200));
		directed_rows.push_back(item_row(10'sd1));
		directed_rows.push_back(cfg_row(REG_INIT_UNC, INIT_UNC_RST));
		directed_rows.push_back(item_row(10'sd399));
		directed_rows.push_back(item_row(NO_ECHO_CM));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 30;
		recv_stall_pct = 88;
		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.kind == ROW_CFG)
				write_reg(row.idx, row.data);
			else
				send_reading(row.reading, row.typed, row.want);
		end

		for (ph = 0; ph < PHASES; ph++) begin
			wait_drained();
			case (ph / 3)
				0: begin
					send_idle_pct = 30;
					recv_stall_pct = 88;
				end
				1: begin
					send_idle_pct = 88;
					recv_stall_pct = 30;
				end
				default: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
			endcase
			start = $urandom_range(2);
			for (k = 0; k < 3; k++)
				write_reg(reg_order[(start + k) % 3], pick_reg_value(reg_order[(start + k) % 3]));
			if ($urandom_range(3) == 0)
				write_reg(REG_UNUSED, $urandom);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (n == PHASE_ITEMS / 2) begin
					wait_drained();
					if ($urandom_range(1) != 0)
						write_reg(REG_INIT_UNC, pick_reg_value(REG_INIT_UNC));
				end else if ($urandom_range(99) == 0) begin
					wait_drained();
				end
				send_reading(pick_reading(), 1'b0, '0);
			end
		end

		wait_drained();
		repeat (END_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

### scalar_kalman_distance_filter_top.f
+incdir+rtl/core
rtl/core/skdf_pkg.sv
rtl/core/skdf_ctrl.sv
rtl/core/skdf_dp.sv
rtl/core/scalar_kalman_distance_filter_top.sv
tb/scalar_kalman_distance_filter_top_tb.sv
